// ----- sv/wft_pkg.sv -----
package wft_pkg;

    localparam int WORD_CHARS  = 32;
    localparam int TABLE_DEPTH = 64;
    localparam int COUNT_BITS  = 16;

    localparam int LEN_W   = $clog2(WORD_CHARS + 1);
    localparam int BUF_AW  = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
    localparam int ENT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int STORE_DEPTH = TABLE_DEPTH * WORD_CHARS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_MOST = 2'd1;
    localparam logic [1:0] OP_LEAST = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam logic [2:0] ST_MATCHED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_QUERY    = 3'd4;
    localparam logic [2:0] ST_NO_TABLE = 3'd5;

    typedef logic [COUNT_BITS-1:0] count_t;

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

endpackage

// ----- sv/wft_ram.sv -----
module wft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/word_frequency_table.sv -----
// word_frequency_table: counts occurrences of words in a table of unique words.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low. opcode 0 delivers one character (char_code), word_end marks the last
// one; opcode 1 / 2 list the entries holding the highest / lowest count.
// A character without word_end gives no result.
// Results appear for one cycle with done high; last_result marks the final one.
// Word end: leading and trailing punctuation is stripped one character at a
// time, then the table is scanned one entry at a time (length first, then each
// character), and an insert copies the word one character at a time.
// Queries take two passes over the count memory: the first finds the highest
// or lowest count, the second lists every entry holding that count.
// busy drops in the cycle the last result is shown; a new transaction may be
// taken at the edge that ends it.
// Reset clears the word length, the entry count and the sequencer; table
// contents are only read once written, so memories need no clearing.
// The receiver cannot stall: every result is shown once, for one cycle.
module word_frequency_table
    import wft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [7:0]  char_code,
    input  logic        word_end,
    output logic        done,
    output logic [2:0]  status,
    output logic [5:0]  entry_index,
    output logic [15:0] entry_count,
    output logic        last_result
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LO_RD = 4'd1;
    localparam logic [3:0] S_LO_CK = 4'd2;
    localparam logic [3:0] S_HI_RD = 4'd3;
    localparam logic [3:0] S_HI_CK = 4'd4;
    localparam logic [3:0] S_E_RD  = 4'd5;
    localparam logic [3:0] S_E_CK  = 4'd6;
    localparam logic [3:0] S_C_RD  = 4'd7;
    localparam logic [3:0] S_C_CK  = 4'd8;
    localparam logic [3:0] S_W_RD  = 4'd9;
    localparam logic [3:0] S_W_WR  = 4'd10;
    localparam logic [3:0] S_Q_RD  = 4'd11;
    localparam logic [3:0] S_Q_CK  = 4'd12;
    localparam logic [3:0] S_L_RD  = 4'd13;
    localparam logic [3:0] S_L_CK  = 4'd14;

    localparam count_t COUNT_MAX = '1;

    logic [3:0]       state_reg, state_next;
    logic [LEN_W-1:0] wlen_reg, wlen_next;
    logic [LEN_W-1:0] lo_reg, lo_next;
    logic [LEN_W-1:0] hi_reg, hi_next;
    logic [LEN_W-1:0] p_reg, p_next;
    logic [ENT_W-1:0] e_reg, e_next;
    logic [ENT_W-1:0] used_reg, used_next;
    count_t           ecnt_reg, ecnt_next;
    count_t           target_reg, target_next;
    logic             max_reg, max_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;

    logic             done_reg, done_next;
    logic [2:0]       status_reg, status_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    count_t           cnt_reg, cnt_next;
    logic             last_reg, last_next;

    logic              buf_we;
    logic [BUF_AW-1:0] buf_raddr;
    logic [7:0]        buf_rdata;
    logic              meta_we;
    logic [IDX_W-1:0]  meta_waddr;
    logic [LEN_W-1:0]  len_wdata, len_rdata;
    count_t            cnt_wdata, cnt_rdata;
    logic              store_we;
    logic [STORE_AW-1:0] store_waddr, store_raddr;
    logic [7:0]        store_rdata;
    logic [LEN_W-1:0]  lo_p, len_w;
    logic [IDX_W-1:0]  e_idx, used_idx;
    logic              accept;

    assign accept   = start && (state_reg == S_IDLE);
    assign lo_p     = lo_reg + p_reg;
    assign len_w    = hi_reg - lo_reg;
    assign e_idx    = e_reg[IDX_W-1:0];
    assign used_idx = used_reg[IDX_W-1:0];
    assign store_raddr = STORE_AW'(e_idx) * STORE_AW'(WORD_CHARS) + STORE_AW'(p_reg);
    assign store_waddr = STORE_AW'(used_idx) * STORE_AW'(WORD_CHARS) + STORE_AW'(p_reg);

    wft_ram #(.WIDTH(8), .DEPTH(WORD_CHARS)) u_buf (
        .clk(clk), .we(buf_we), .waddr(wlen_reg[BUF_AW-1:0]), .wdata(char_code),
        .raddr(buf_raddr), .rdata(buf_rdata)
    );

    wft_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .clk(clk), .we(store_we), .waddr(store_waddr), .wdata(buf_rdata),
        .raddr(store_raddr), .rdata(store_rdata)
    );

    wft_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_DEPTH)) u_len (
        .clk(clk), .we(meta_we && (state_reg == S_W_RD)), .waddr(meta_waddr),
        .wdata(len_wdata), .raddr(e_idx), .rdata(len_rdata)
    );

    wft_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_cnt (
        .clk(clk), .we(meta_we), .waddr(meta_waddr),
        .wdata(cnt_wdata), .raddr(e_idx), .rdata(cnt_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        wlen_next   = wlen_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        p_next      = p_reg;
        e_next      = e_reg;
        used_next   = used_reg;
        ecnt_next   = ecnt_reg;
        target_next = target_reg;
        max_next    = max_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        buf_we      = 1'b0;
        buf_raddr   = lo_reg[BUF_AW-1:0];
        meta_we     = 1'b0;
        meta_waddr  = e_idx;
        len_wdata   = len_w;
        cnt_wdata   = ecnt_reg;
        store_we    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (opcode == OP_CHAR)
                    begin
                        if (wlen_reg < LEN_W'(WORD_CHARS))
                        begin
                            buf_we    = 1'b1;
                            wlen_next = wlen_reg + 1'b1;
                        end
                        if (word_end)
                        begin
                            lo_next    = '0;
                            hi_next    = wlen_next;
                            wlen_next  = '0;
                            state_next = S_LO_RD;
                        end
                    end
                    else if (opcode == OP_MOST || opcode == OP_LEAST)
                    begin
                        max_next = (opcode == OP_MOST);
                        if (used_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NO_TABLE;
                            idx_next    = '0;
                            cnt_next    = '0;
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            e_next     = '0;
                            state_next = S_Q_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_LO_RD:
            begin
                buf_raddr  = lo_reg[BUF_AW-1:0];
                state_next = S_LO_CK;
            end
            S_LO_CK:
            begin
                if (lo_reg < hi_reg && is_punct(buf_rdata))
                begin
                    lo_next    = lo_reg + 1'b1;
                    state_next = S_LO_RD;
                end
                else
                begin
                    state_next = S_HI_RD;
                end
            end
            S_HI_RD:
            begin
                buf_raddr  = BUF_AW'(hi_reg - 1'b1);
                state_next = S_HI_CK;
            end
            S_HI_CK:
            begin
                if (hi_reg > lo_reg && is_punct(buf_rdata))
                begin
                    hi_next    = hi_reg - 1'b1;
                    state_next = S_HI_RD;
                end
                else if (hi_reg == lo_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_EMPTY;
                    idx_next    = '0;
                    cnt_next    = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    e_next     = '0;
                    state_next = S_E_RD;
                end
            end
            S_E_RD:
            begin
                if (e_reg >= used_reg)
                begin
                    if (used_reg >= ENT_W'(TABLE_DEPTH))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                        idx_next    = '0;
                        cnt_next    = '0;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        p_next     = '0;
                        state_next = S_W_RD;
                    end
                end
                else
                begin
                    state_next = S_E_CK;
                end
            end
            S_E_CK:
            begin
                ecnt_next = cnt_rdata;
                if (len_rdata == len_w)
                begin
                    p_next     = '0;
                    state_next = S_C_RD;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_E_RD;
                end
            end
            S_C_RD:
            begin
                buf_raddr = lo_p[BUF_AW-1:0];
                if (p_reg == len_w)
                begin
                    cnt_wdata   = (ecnt_reg != COUNT_MAX) ? ecnt_reg + 1'b1 : ecnt_reg;
                    meta_we     = 1'b1;
                    meta_waddr  = e_idx;
                    done_next   = 1'b1;
                    status_next = ST_MATCHED;
                    idx_next    = e_idx;
                    cnt_next    = cnt_wdata;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_C_CK;
                end
            end
            S_C_CK:
            begin
                if (store_rdata == buf_rdata)
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = S_C_RD;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_E_RD;
                end
            end
            S_W_RD:
            begin
                buf_raddr = lo_p[BUF_AW-1:0];
                if (p_reg == len_w)
                begin
                    meta_we     = 1'b1;
                    meta_waddr  = used_idx;
                    cnt_wdata   = count_t'(1);
                    used_next   = used_reg + 1'b1;
                    done_next   = 1'b1;
                    status_next = ST_INSERTED;
                    idx_next    = used_idx;
                    cnt_next    = count_t'(1);
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_W_WR;
                end
            end
            S_W_WR:
            begin
                store_we   = 1'b1;
                p_next     = p_reg + 1'b1;
                state_next = S_W_RD;
            end
            S_Q_RD:
            begin
                if (e_reg == used_reg)
                begin
                    e_next     = '0;
                    pend_next  = 1'b0;
                    state_next = S_L_RD;
                end
                else
                begin
                    state_next = S_Q_CK;
                end
            end
            S_Q_CK:
            begin
                if (e_reg == '0 || (max_reg ? (cnt_rdata > target_reg)
                                            : (cnt_rdata < target_reg)))
                begin
                    target_next = cnt_rdata;
                end
                e_next     = e_reg + 1'b1;
                state_next = S_Q_RD;
            end
            S_L_RD:
            begin
                if (e_reg == used_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_QUERY;
                    idx_next    = pidx_reg;
                    cnt_next    = target_reg;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_L_CK;
                end
            end
            S_L_CK:
            begin
                if (cnt_rdata == target_reg)
                begin
                    if (pend_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_QUERY;
                        idx_next    = pidx_reg;
                        cnt_next    = target_reg;
                        last_next   = 1'b0;
                    end
                    pend_next = 1'b1;
                    pidx_next = e_idx;
                end
                e_next     = e_reg + 1'b1;
                state_next = S_L_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wlen_reg  <= '0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wlen_reg  <= wlen_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        p_reg      <= p_next;
        e_reg      <= e_next;
        ecnt_reg   <= ecnt_next;
        target_reg <= target_next;
        max_reg    <= max_next;
        pidx_reg   <= pidx_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        last_reg   <= last_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_index = 6'(idx_reg);
    assign entry_count = 16'(cnt_reg);
    assign last_result = last_reg;

endmodule

// ----- sv/wft_checker.sv -----
module wft_checker
    import wft_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  opcode,
    input logic        done,
    input logic [2:0]  status,
    input logic [5:0]  entry_index,
    input logic [15:0] entry_count,
    input logic        last_result
);

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ST_NO_TABLE)
        else $error("status code out of range");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_QUERY |-> last_result)
        else $error("non-query result not marked last");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_EMPTY || status == ST_FULL || status == ST_NO_TABLE)
        |-> entry_index == 6'd0 && entry_count == 16'd0)
        else $error("payload of an empty/full result not zero");

    a_busy_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> last_result != busy)
        else $error("busy does not track the last result of a transaction");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == OP_MOST |=> busy || (done && last_result))
        else $error("query transaction not taken up");

endmodule

bind word_frequency_table wft_checker u_wft_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
    .done(done), .status(status), .entry_index(entry_index),
    .entry_count(entry_count), .last_result(last_result)
);

// ----- dv/word_frequency_table_tb.sv -----
module word_frequency_table_tb;
    import wft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int VOCAB_SIZE     = 72;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  index;
        logic [15:0] count;
        logic        last;
    } table_result_t;

    class freq_scoreboard;
        table_result_t pending[$];
        logic [7:0]    word_bytes[WORD_CHARS];
        int            word_len;
        logic [7:0]    stored_words[TABLE_DEPTH][WORD_CHARS];
        int            stored_lens[TABLE_DEPTH];
        int            counts[TABLE_DEPTH];
        int            used;
        int            errors;
        int            checked;
        int            full_seen;

        function void push(logic [2:0] st, int idx, int cnt, logic lst);
            table_result_t r;
            r.status = st;
            r.index  = idx[5:0];
            r.count  = cnt[15:0];
            r.last   = lst;
            pending.push_back(r);
        endfunction

        function bit punct(logic [7:0] c);
            return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
                   (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
        endfunction

        function void close_word();
            int lo;
            int hi;
            int len;
            bit same;
            lo = 0;
            hi = word_len;
            word_len = 0;
            while (lo < hi && punct(word_bytes[lo])) lo++;
            while (hi > lo && punct(word_bytes[hi-1])) hi--;
            len = hi - lo;
            if (len == 0) begin
                push(ST_EMPTY, 0, 0, 1'b1);
                return;
            end
            for (int e = 0; e < used; e++) begin
                same = (stored_lens[e] == len);
                for (int p = 0; p < len && same; p++)
                    if (stored_words[e][p] != word_bytes[lo+p]) same = 0;
                if (same) begin
                    if (counts[e] < (1 << COUNT_BITS) - 1) counts[e]++;
                    push(ST_MATCHED, e, counts[e], 1'b1);
                    return;
                end
            end
            if (used >= TABLE_DEPTH) begin
                full_seen++;
                push(ST_FULL, 0, 0, 1'b1);
                return;
            end
            for (int p = 0; p < len; p++) stored_words[used][p] = word_bytes[lo+p];
            stored_lens[used] = len;
            counts[used] = 1;
            push(ST_INSERTED, used, 1, 1'b1);
            used++;
        endfunction

        function void list_extreme(bit want_max);
            int target;
            int hits;
            int n;
            if (used == 0) begin
                push(ST_NO_TABLE, 0, 0, 1'b1);
                return;
            end
            target = counts[0];
            for (int e = 1; e < used; e++)
                if (want_max ? counts[e] > target : counts[e] < target) target = counts[e];
            hits = 0;
            for (int e = 0; e < used; e++) if (counts[e] == target) hits++;
            n = 0;
            for (int e = 0; e < used; e++)
                if (counts[e] == target) begin
                    n++;
                    push(ST_QUERY, e, target, n == hits);
                end
        endfunction

        function void note_input(logic [1:0] op, logic [7:0] ch, logic fin);
            if (op == OP_CHAR) begin
                if (word_len < WORD_CHARS) begin
                    word_bytes[word_len] = ch;
                    word_len++;
                end
                if (fin) close_word();
            end else if (op == OP_MOST) begin
                list_extreme(1'b1);
            end else if (op == OP_LEAST) begin
                list_extreme(1'b0);
            end
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status=%0d index=%0d count=%0d last=%0d",
                         $time, got.status, got.index, got.count, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status)
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            if (got.index != want.index)
                $display("%0t: entry_index expected %0d actual %0d", $time, want.index, got.index);
            if (got.count != want.count)
                $display("%0t: entry_count expected %0d actual %0d", $time, want.count, got.count);
            if (got.last != want.last)
                $display("%0t: last_result expected %0d actual %0d", $time, want.last, got.last);
            if (got != want) errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic        word_end;
    logic        done;
    logic [2:0]  status;
    logic [5:0]  entry_index;
    logic [15:0] entry_count;
    logic        last_result;

    freq_scoreboard sb;
    int             idle_pct;
    int             items_sent;
    int             stall_cycles;
    logic [7:0]     vocab[VOCAB_SIZE][$];

    word_frequency_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .char_code   (char_code),
        .word_end    (word_end),
        .done        (done),
        .status      (status),
        .entry_index (entry_index),
        .entry_count (entry_count),
        .last_result (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({status, entry_index, entry_count, last_result});
    end

    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || done))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[word_frequency_table] ERROR");
            $finish;
        end
    end

    task automatic send(logic [1:0] op, logic [7:0] ch, logic fin);
        start     <= 1'b1;
        opcode    <= op;
        char_code <= ch;
        word_end  <= fin;
        do @(posedge clk); while (busy);
        sb.note_input(op, ch, fin);
        if (op != OP_NOP) items_sent++;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_word(logic [7:0] bytes[$]);
        foreach (bytes[i]) send(OP_CHAR, bytes[i], i == bytes.size() - 1);
    endtask

    function automatic logic [7:0] rand_punct();
        case ($urandom_range(3))
            0: return 8'($urandom_range(8'h21, 8'h2F));
            1: return 8'($urandom_range(8'h3A, 8'h40));
            2: return 8'($urandom_range(8'h5B, 8'h60));
            default: return 8'($urandom_range(8'h7B, 8'h7E));
        endcase
    endfunction

    task automatic random_word();
        logic [7:0] w[$];
        int kind;
        kind = $urandom_range(99);
        if (kind < 80)
        begin
            repeat ($urandom_range(2) == 0 ? $urandom_range(1, 2) : 0) w.push_back(rand_punct());
            w = {w, vocab[$urandom_range(VOCAB_SIZE - 1)]};
            repeat ($urandom_range(2) == 0 ? $urandom_range(1, 2) : 0) w.push_back(rand_punct());
        end
        else if (kind < 88)
            repeat ($urandom_range(1, 3)) w.push_back(rand_punct());
        else if (kind < 94)
            repeat ($urandom_range(1, 6)) w.push_back(8'($urandom_range(255)));
        else
            repeat ($urandom_range(30, 38)) w.push_back(8'($urandom_range(8'h61, 8'h62)));
        send_word(w);
    endtask

    initial
    begin
        logic [7:0] w[$];
        sb = new();
        start        = 1'b0;
        opcode       = OP_CHAR;
        char_code    = 8'h00;
        word_end     = 1'b0;
        rst_n        = 1'b0;
        idle_pct     = 0;
        items_sent   = 0;
        stall_cycles = 0;
        for (int i = 0; i < VOCAB_SIZE; i++)
        begin
            vocab[i].push_back(8'h61 + 8'(i % 26));
            vocab[i].push_back(8'h41 + 8'(i / 26));
            repeat ($urandom_range(3)) vocab[i].push_back(8'($urandom_range(8'h61, 8'h7A)));
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, empty word, null byte, high byte, query and nop mid-word, repeat match
        send(OP_MOST, 8'h00, 1'b0);
        send(OP_LEAST, 8'hFF, 1'b1);
        send_word('{8'h21, 8'h7E});
        send_word('{8'h00});
        send_word('{8'h2E, 8'hFF, 8'h5B});
        send(OP_CHAR, 8'h41, 1'b0);
        send(OP_MOST, 8'h00, 1'b0);
        send(OP_NOP, 8'hAA, 1'b1);
        send(OP_CHAR, 8'h42, 1'b1);
        send_word('{8'h41, 8'h42, 8'h3F});
        for (int i = 0; i < 3; i++) w.push_back(8'h7A);
        send_word(w);
        send(OP_LEAST, 8'h00, 1'b0);

        while (items_sent < 480)
        begin
            case ((items_sent / 120) % 3)
                0: idle_pct = 0;
                1: idle_pct = 73;
                default: idle_pct = 7;
            endcase
            case ($urandom_range(19))
                0: send(OP_MOST, 8'($urandom_range(255)), 1'($urandom_range(1)));
                1: send(OP_LEAST, 8'($urandom_range(255)), 1'($urandom_range(1)));
                2: send(OP_NOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
                default: random_word();
            endcase
            if (items_sent > 4000) break;
        end
        start <= 1'b0;

        while (sb.pending.size() != 0 || busy) @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Sent %0d transactions, checked %0d results, %0d entries in use,",
                 items_sent, sb.checked, sb.used);
        $display("table-full hits %0d, across idle-free and idle-heavy phases.", sb.full_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[word_frequency_table] OK");
        else
            $display("[word_frequency_table] ERROR");
        $finish;
    end

endmodule

// ----- word_frequency_table.f -----
sv/wft_pkg.sv
sv/wft_ram.sv
sv/word_frequency_table.sv
sv/wft_checker.sv
dv/word_frequency_table_tb.sv
